// ===== sv/bf_pkg.sv =====
// Shared types and constants for the 3x3 zero-padded box filter.
`default_nettype none
package bf_pkg;

   localparam int SAMPLE_W      = 17;
   localparam int COLSUM_W      = 19;
   localparam int SUM_W         = 21;
   localparam int GRID_WIDTH_W  = 11;
   localparam int GRID_HEIGHT_W = 13;
   localparam int ROW_W         = 13;
   localparam int MAX_HEIGHT    = 4096;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_HEIGHT = 2'd1;

   localparam logic [GRID_WIDTH_W-1:0]  GRID_WIDTH_RESET  = 11'd16;
   localparam logic [GRID_HEIGHT_W-1:0] GRID_HEIGHT_RESET = 13'd16;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_PAD    = 1'b1;

   localparam int QUEUE_DEPTH   = 4;
   localparam int QUEUE_PTR_W   = 2;
   localparam int QUEUE_LEVEL_W = 3;

   // floor(s / 9) = (s * DIV9_MUL) >> DIV9_SHIFT, exact for s < 2**21
   localparam logic [SUM_W-1:0] DIV9_MUL   = 21'd1864136;
   localparam int               DIV9_SHIFT = 24;

   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef logic [2:0][SAMPLE_W-1:0] column_type;

   typedef struct packed {
      logic       operation;
      sample_type sample;
   } req_payload_type;

   typedef struct packed {
      sample_type value;
      logic       last;
   } rsp_payload_type;

   typedef struct packed {
      logic emit;
      logic top;
      logic use_old1;
      logic use_new;
      logic last;
   } stencil_ctl_type;

   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic             last;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type data;
   } push_type;

endpackage
`default_nettype wire

// ===== sv/bf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bf_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== sv/bf_front.sv =====
// Front end: position tracking, line buffers, 3x3 window and partial sums.
`default_nettype none
module bf_front #(
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output      logic                             req_ready,
   input  wire bf_pkg::req_payload_type          req_payload,
   input  wire logic                             csr_valid,
   output      logic                             csr_ready,
   input  wire logic [bf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [bf_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire logic [bf_pkg::QUEUE_LEVEL_W-1:0] queue_level,
   output      bf_pkg::push_type                 push
);
   import bf_pkg::*;

   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int WIDTH_VAL_W = $clog2(MAX_WIDTH + 1);

   function automatic logic [COLSUM_W-1:0] col_sum(column_type c, logic with_top);
      logic [COLSUM_W-1:0] t;
      t = with_top ? COLSUM_W'(c[0]) : '0;
      return t + COLSUM_W'(c[1]) + COLSUM_W'(c[2]);
   endfunction

   logic [GRID_WIDTH_W-1:0]  grid_width_ff;
   logic [GRID_HEIGHT_W-1:0] grid_height_ff;
   logic [WIDTH_VAL_W-1:0]   w_val;
   logic [ROW_W-1:0]         h_val;
   logic                     csr_known;
   logic                     restart;

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             accept;
   logic             first_col;
   logic             wrap;
   sample_type       v0;
   stencil_ctl_type  ctl0;

   logic            s1_valid_ff;
   logic [COL_W-1:0] s1_col_ff;
   sample_type      s1_v_ff;
   stencil_ctl_type s1_ctl_ff;
   logic            s1_byp_ff;
   sample_type      s1_byp_top_ff;
   sample_type      s1_byp_mid_ff;
   sample_type      above_rd, middle_rd;
   sample_type      top1, mid1;
   logic            byp_in;
   column_type      new_col;
   column_type      wcol1_ff, wcol2_ff;

   logic                s2_valid_ff;
   logic [COLSUM_W-1:0] s2_p1_ff, s2_p2_ff, s2_p3_ff;
   logic                s2_last_ff;

   // configuration
   assign csr_ready = 1'b1;

   always_comb begin
      case (csr_index)
         CSR_GRID_WIDTH:  csr_known = 1'b1;
         CSR_GRID_HEIGHT: csr_known = 1'b1;
         default:         csr_known = 1'b0;
      endcase
   end

   assign restart = csr_valid && csr_known;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= GRID_WIDTH_RESET;
         grid_height_ff <= GRID_HEIGHT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_GRID_WIDTH:  grid_width_ff  <= csr_wdata[GRID_WIDTH_W-1:0];
            CSR_GRID_HEIGHT: grid_height_ff <= csr_wdata[GRID_HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (grid_width_ff < GRID_WIDTH_W'(2)) begin
         w_val = WIDTH_VAL_W'(2);
      end else if (32'(grid_width_ff) > 32'(MAX_WIDTH)) begin
         w_val = WIDTH_VAL_W'(MAX_WIDTH);
      end else begin
         w_val = WIDTH_VAL_W'(grid_width_ff);
      end
      if (grid_height_ff < GRID_HEIGHT_W'(2)) begin
         h_val = ROW_W'(2);
      end else if (grid_height_ff > GRID_HEIGHT_W'(MAX_HEIGHT)) begin
         h_val = ROW_W'(MAX_HEIGHT);
      end else begin
         h_val = ROW_W'(grid_height_ff);
      end
   end

   // stage 0: accept and classify
   assign req_ready = (32'(queue_level) + 32'(s1_valid_ff && s1_ctl_ff.emit)
                       + 32'(s2_valid_ff)) < 32'(QUEUE_DEPTH);
   assign accept    = req_valid && req_ready;
   assign first_col = (col_ff == '0);
   assign wrap      = (32'(col_ff) + 32'd1) >= 32'(w_val);

   always_comb begin
      if (req_payload.operation == OP_SAMPLE && row_ff < h_val) begin
         v0 = req_payload.sample;
      end else begin
         v0 = '0;
      end
      ctl0.emit     = first_col ? (row_ff >= ROW_W'(2)) : (row_ff >= ROW_W'(1));
      ctl0.top      = first_col ? (row_ff >= ROW_W'(3)) : (row_ff >= ROW_W'(2));
      ctl0.use_old1 = first_col || (32'(col_ff) >= 32'd2);
      ctl0.use_new  = !first_col;
      ctl0.last     = first_col && (row_ff == h_val + ROW_W'(1));
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (ctl0.last) begin
            col_in = '0;
            row_in = '0;
         end else if (wrap) begin
            col_in = '0;
            row_in = row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // line buffers: read at stage 0, rotate at stage 1
   bf_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_WIDTH)) u_above (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (mid1),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (above_rd)
   );

   bf_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_WIDTH)) u_middle (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (s1_v_ff),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (middle_rd)
   );

   // same column back to back (frame restart): forward the pending write
   assign byp_in = s1_valid_ff && (s1_col_ff == col_ff);
   assign top1   = s1_byp_ff ? s1_byp_top_ff : above_rd;
   assign mid1   = s1_byp_ff ? s1_byp_mid_ff : middle_rd;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff     <= col_ff;
         s1_v_ff       <= v0;
         s1_ctl_ff     <= ctl0;
         s1_byp_ff     <= byp_in;
         s1_byp_top_ff <= mid1;
         s1_byp_mid_ff <= s1_v_ff;
      end
   end

   // stage 1: window shift and column sums
   always_comb begin
      new_col[0] = top1;
      new_col[1] = mid1;
      new_col[2] = s1_v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         wcol1_ff <= '0;
         wcol2_ff <= '0;
      end else if (s1_valid_ff) begin
         if (s1_ctl_ff.last) begin
            wcol1_ff <= '0;
            wcol2_ff <= '0;
         end else begin
            wcol1_ff <= wcol2_ff;
            wcol2_ff <= new_col;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff && s1_ctl_ff.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         s2_p1_ff   <= s1_ctl_ff.use_old1 ? col_sum(wcol1_ff, s1_ctl_ff.top) : '0;
         s2_p2_ff   <= col_sum(wcol2_ff, s1_ctl_ff.top);
         s2_p3_ff   <= s1_ctl_ff.use_new ? col_sum(new_col, s1_ctl_ff.top) : '0;
         s2_last_ff <= s1_ctl_ff.last;
      end
   end

   // stage 2: neighborhood sum into the queue
   always_comb begin
      push.valid     = s2_valid_ff;
      push.data.sum  = SUM_W'(s2_p1_ff) + SUM_W'(s2_p2_ff) + SUM_W'(s2_p3_ff);
      push.data.last = s2_last_ff;
   end

   a_window_cleared: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_ctl_ff.last) |=> (wcol1_ff == '0 && wcol2_ff == '0))
      else $error("window not cleared after frame end");

   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      row_ff <= h_val + ROW_W'(1))
      else $error("row position past flush row");

endmodule
`default_nettype wire

// ===== sv/bf_queue.sv =====
// Small register FIFO between the stencil front end and the divide back end.
`default_nettype none
module bf_queue (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire bf_pkg::push_type                 push,
   input  wire logic                             pop,
   output      bf_pkg::push_type                 head,
   output      logic [bf_pkg::QUEUE_LEVEL_W-1:0] level
);
   import bf_pkg::*;

   entry_type                entries [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_LEVEL_W-1:0] level_ff;

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entries[wr_ptr_ff] <= push.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         if (push.valid) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_W'(1);
         end
         if (push.valid && !pop) begin
            level_ff <= level_ff + QUEUE_LEVEL_W'(1);
         end else if (pop && !push.valid) begin
            level_ff <= level_ff - QUEUE_LEVEL_W'(1);
         end
      end
   end

   assign head.valid = (level_ff != '0);
   assign head.data  = entries[rd_ptr_ff];
   assign level      = level_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> (32'(level_ff) < QUEUE_DEPTH || pop))
      else $error("queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (level_ff != '0))
      else $error("queue underflow");

endmodule
`default_nettype wire

// ===== sv/bf_back.sv =====
// Back end: divide the neighborhood sum by nine and hold the result beat.
`default_nettype none
module bf_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire bf_pkg::push_type        head,
   output      logic                    pop,
   output      logic                    rsp_valid,
   input  wire logic                    rsp_ready,
   output      bf_pkg::rsp_payload_type rsp_payload
);
   import bf_pkg::*;

   logic                   rsp_valid_ff;
   rsp_payload_type        rsp_payload_ff;
   logic                   load;
   logic [2*SUM_W-1:0]     product;

   assign load    = head.valid && (!rsp_valid_ff || rsp_ready);
   assign pop     = load;
   assign product = (2*SUM_W)'(head.data.sum) * (2*SUM_W)'(DIV9_MUL);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_payload_ff.value <= product[DIV9_SHIFT +: SAMPLE_W];
         rsp_payload_ff.last  <= head.data.last;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule
`default_nettype wire

// ===== sv/box_filter_3x3_zero_pad.sv =====
// Top level of the streaming 3x3 zero-padded box filter.
//
// req_* takes one grid cell per beat in row-major order (operation selects
// cell or pad). After the last cell of a frame send grid_width+1 pad beats
// to flush; the beat carrying last=1 on rsp_* closes the frame and the next
// beat starts a new one. Results lag the input by one row plus one cell.
// rsp_* gives value = floor(sum of 3x3 neighborhood / 9), Q1.16.
// csr_* writes grid_width (index 0) or grid_height (index 1); any such
// write restarts the frame. Write it only while the block is idle.
// Throughput is one beat per clock while the queue has room: line buffers
// are read on acceptance and rewritten in the following cycle.
// The beat causing a result passes the stage 1 and stage 2 registers, the
// queue and the result register before rsp_valid rises.
// If rsp_ready is held low the four-entry queue fills and req_ready drops;
// no beat is lost, and flow resumes at full rate when rsp_ready returns.
// Reset (synchronous) restores 16x16 and restarts the frame; line buffer
// contents are not cleared and are always written before they count.
`default_nettype none
module box_filter_3x3_zero_pad #(
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output      logic                           req_ready,
   input  wire bf_pkg::req_payload_type        req_payload,
   output      logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   output      bf_pkg::rsp_payload_type        rsp_payload,
   input  wire logic                           csr_valid,
   output      logic                           csr_ready,
   input  wire logic [bf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [bf_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import bf_pkg::*;

   push_type                 push;
   push_type                 head;
   logic                     pop;
   logic [QUEUE_LEVEL_W-1:0] level;

   bf_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .queue_level (level),
      .push        (push)
   );

   bf_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .level (level)
   );

   bf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire
